[design/tcpph_pkg.sv]
// ---------------------------------------------------------------------------
// tcpph_pkg
// Shared types, constants and one's-complement helpers of the checksum core.
// ---------------------------------------------------------------------------
`default_nettype none

package tcpph_pkg;

  localparam logic [15:0] SUM_ALL_ONES = 16'hFFFF;
  localparam logic [15:0] SUM_ZERO     = 16'h0000;

  typedef struct packed {
    logic [15:0] data_word;
    logic        first;
    logic        last;
    logic        half_word;
    logic        use_pseudo;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  protocol;
    logic [15:0] seg_length;
  } item_t;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [15:0] sum;
  } part_t;

  // One's-complement addition with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  // Folds a sum of up to eight 16-bit terms down to 16 bits.
  function automatic logic [15:0] oc_fold19(input logic [18:0] x);
    logic [16:0] f;
    f = {1'b0, x[15:0]} + {14'd0, x[18:16]};
    return f[15:0] + {15'd0, f[16]};
  endfunction

endpackage

`default_nettype wire

[design/tcpph_front.sv]
// ---------------------------------------------------------------------------
// tcpph_front
// Input register and per-word term sum, including the optional pseudo header.
// ---------------------------------------------------------------------------
`default_nettype none

module tcpph_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire tcpph_pkg::item_t in_item_i,
  output logic                 part_valid_o,
  input  wire logic            part_ready_i,
  output tcpph_pkg::part_t     part_o
);
  import tcpph_pkg::*;

  logic        in_valid_q;
  item_t       item_q;
  logic        part_valid_q;
  part_t       part_q;
  logic        adv_part;
  logic        adv_in;
  logic        pseudo_en;
  logic [15:0] word;
  logic [18:0] total;
  part_t       part_d;

  assign adv_part  = ~part_valid_q | part_ready_i;
  assign adv_in    = ~in_valid_q | adv_part;
  assign in_ready_o = adv_in;

  always_comb begin
    pseudo_en = item_q.first & item_q.use_pseudo;
    word      = item_q.half_word ? {item_q.data_word[15:8], 8'h00} : item_q.data_word;
    total     = {3'd0, word};
    if (pseudo_en) begin
      total = total
            + {3'd0, item_q.src_addr[31:16]} + {3'd0, item_q.src_addr[15:0]}
            + {3'd0, item_q.dst_addr[31:16]} + {3'd0, item_q.dst_addr[15:0]}
            + {11'd0, item_q.protocol} + {3'd0, item_q.seg_length};
    end
    part_d.first = item_q.first;
    part_d.last  = item_q.last;
    part_d.sum   = oc_fold19(total);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      part_valid_q <= 1'b0;
    end else begin
      if (adv_in) begin
        in_valid_q <= in_valid_i;
      end
      if (adv_part) begin
        part_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      item_q <= in_item_i;
    end
    if (adv_part && in_valid_q) begin
      part_q <= part_d;
    end
  end

  assign part_valid_o = part_valid_q;
  assign part_o       = part_q;

endmodule

`default_nettype wire

[design/tcpph_accum.sv]
// ---------------------------------------------------------------------------
// tcpph_accum
// Running one's-complement sum and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tcpph_accum (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             part_valid_i,
  output logic                  part_ready_o,
  input  wire tcpph_pkg::part_t part_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [15:0]           checksum_value_o,
  output logic                  check_ok_o
);
  import tcpph_pkg::*;

  logic [15:0] running_sum_q;
  logic [15:0] running_sum_d;
  logic        out_valid_q;
  logic [15:0] checksum_q;
  logic        check_ok_q;
  logic        out_free;
  logic        take;

  assign out_free     = ~out_valid_q | out_ready_i;
  assign take         = part_valid_i & (~part_i.last | out_free);
  assign part_ready_o = ~part_valid_i | take;

  assign running_sum_d = part_i.first ? part_i.sum : oc_add(running_sum_q, part_i.sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_sum_q <= 16'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        running_sum_q <= running_sum_d;
      end
      if (take && part_i.last) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && part_i.last) begin
      checksum_q <= ~running_sum_d;
      check_ok_q <= (running_sum_d == SUM_ALL_ONES) || (running_sum_d == SUM_ZERO);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign checksum_value_o = checksum_q;
  assign check_ok_o       = check_ok_q;

endmodule

`default_nettype wire

[design/transport_checksum_pseudo_header_core.sv]
// ---------------------------------------------------------------------------
// transport_checksum_pseudo_header_core
// Internet checksum over 16-bit words with an optional IPv4 pseudo header.
// ---------------------------------------------------------------------------
// Channel   Direction  Carries
// s_axis    in         one packet word per handshake, with first/half/pseudo flags
// m_axis    out        checksum and check flag, one word per last input word
//
// One word is accepted per cycle unless a stall on m_axis holds it back; a last
// word passes the input, term and result registers. The pseudo header is summed
// with the first word in the term stage, the running sum updated in the accumulate stage.
// Reset clears the running sum to zero and empties all stages.
// A stall on m_axis only blocks when a result word is waiting to leave.
// ---------------------------------------------------------------------------
`default_nettype none

module transport_checksum_pseudo_header_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // data_word[15:0], src_addr[47:16], dst_addr[79:48], protocol[87:80],
  // seg_length[103:88]
  input  wire logic [103:0] s_axis_tdata_i,
  input  wire logic         s_axis_tlast_i,
  // first[0], half_word[1], use_pseudo[2]
  input  wire logic [2:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // checksum_value[15:0]
  output logic [15:0]       m_axis_tdata_o,
  // check_ok[0]
  output logic [0:0]        m_axis_tuser_o
);
  import tcpph_pkg::*;

  item_t in_item;
  logic  part_valid;
  logic  part_ready;
  part_t part;
  logic  check_ok;

  always_comb begin
    in_item.data_word  = s_axis_tdata_i[15:0];
    in_item.first      = s_axis_tuser_i[0];
    in_item.last       = s_axis_tlast_i;
    in_item.half_word  = s_axis_tuser_i[1];
    in_item.use_pseudo = s_axis_tuser_i[2];
    in_item.src_addr   = s_axis_tdata_i[47:16];
    in_item.dst_addr   = s_axis_tdata_i[79:48];
    in_item.protocol   = s_axis_tdata_i[87:80];
    in_item.seg_length = s_axis_tdata_i[103:88];
  end

  tcpph_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .part_valid_o (part_valid),
    .part_ready_i (part_ready),
    .part_o       (part)
  );

  tcpph_accum u_accum (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .part_valid_i     (part_valid),
    .part_ready_o     (part_ready),
    .part_i           (part),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .checksum_value_o (m_axis_tdata_o),
    .check_ok_o       (check_ok)
  );

  assign m_axis_tuser_o = check_ok;

endmodule

`default_nettype wire
